### rtl/idll_pkg.sv
// Shared types, codes and controller/datapath interface for the indexed list.
`default_nettype none

package idll_pkg;

  // Request codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic        [1:0]  action;
    logic        [5:0]  slot;
    logic signed [31:0] item_value;
    logic        [5:0]  rank;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [5:0]  result_slot;
    logic signed [31:0] found_value;
    logic        [5:0]  head_slot;
    logic        [5:0]  tail_slot;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_WALK,
    S_VREAD,
    S_INS_HEAD,
    S_INS_A,
    S_INS_B,
    S_REM_A,
    S_REM_B,
    S_RESP
  } state_e;

  // Address source for the shared read port
  typedef enum logic [1:0] {
    A_HOLD,
    A_REQ,
    A_HEAD,
    A_WALK
  } addr_e;

  // Memory write phase
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INS_HEAD,
    WR_INS_A,
    WR_INS_B,
    WR_REM_A,
    WR_REM_B
  } wr_e;

  // Result register update
  typedef enum logic [2:0] {
    RES_NONE,
    RES_BAD,
    RES_FULL,
    RES_INS,
    RES_FIND,
    RES_OK
  } res_e;

  typedef struct packed {
    logic  latch;
    addr_e addr_sel;
    logic  alloc;
    logic  cap;
    logic  cnt_load;
    logic  cnt_dec;
    wr_e   wr;
    res_e  res;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       empty;
    logic       full;
    logic       in_use;
    logic       rank_zero;
    logic       cnt_zero;
    logic       walk_end;
  } sts_t;

endpackage

`default_nettype wire

### rtl/idll_ctrl.sv
// Sequencing state machine of the indexed list: decodes requests and drives the datapath.
`default_nettype none

module idll_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire idll_pkg::sts_t sts_i,
  output idll_pkg::cmd_t     cmd_o
);
  import idll_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_RESP;
        case (sts_i.action)
          ACT_INSERT: begin
            if (sts_i.empty) begin
              if (!sts_i.full) state_d = S_INS_HEAD;
            end else if (sts_i.in_use && !sts_i.full) begin
              state_d = S_INS_A;
            end
          end
          ACT_REMOVE: begin
            if (sts_i.in_use) state_d = S_REM_A;
          end
          ACT_FIND: begin
            if (!sts_i.empty) state_d = sts_i.rank_zero ? S_VREAD : S_WALK;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_WALK: begin
        if (sts_i.walk_end)      state_d = S_RESP;
        else if (sts_i.cnt_zero) state_d = S_VREAD;
      end
      S_VREAD:    state_d = S_RESP;
      S_INS_HEAD: state_d = S_RESP;
      S_INS_A:    state_d = S_INS_B;
      S_INS_B:    state_d = S_RESP;
      S_REM_A:    state_d = S_REM_B;
      S_REM_B:    state_d = S_RESP;
      S_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = A_HOLD;
    cmd_o.wr       = WR_NONE;
    cmd_o.res      = RES_NONE;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.addr_sel = A_REQ;
        cmd_o.latch    = in_valid_i;
      end
      S_EVAL: begin
        cmd_o.addr_sel = A_HEAD;
        case (sts_i.action)
          ACT_INSERT: begin
            if (sts_i.empty) begin
              if (sts_i.full) begin
                cmd_o.res = RES_FULL;
              end else begin
                cmd_o.alloc = 1'b1;
                cmd_o.res   = RES_INS;
              end
            end else if (!sts_i.in_use) begin
              cmd_o.res = RES_BAD;
            end else if (sts_i.full) begin
              cmd_o.res = RES_FULL;
            end else begin
              cmd_o.alloc = 1'b1;
              cmd_o.cap   = 1'b1;
              cmd_o.res   = RES_INS;
            end
          end
          ACT_REMOVE: begin
            if (sts_i.in_use) begin
              cmd_o.cap = 1'b1;
              cmd_o.res = RES_OK;
            end else begin
              cmd_o.res = RES_BAD;
            end
          end
          ACT_FIND: begin
            if (sts_i.empty) begin
              cmd_o.res = RES_BAD;
            end else if (!sts_i.rank_zero) begin
              cmd_o.cnt_load = 1'b1;
            end
          end
          default: cmd_o.res = RES_BAD;
        endcase
      end
      S_WALK: begin
        cmd_o.addr_sel = A_WALK;
        if (sts_i.walk_end) begin
          cmd_o.res = RES_BAD;
        end else if (!sts_i.cnt_zero) begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_VREAD:    cmd_o.res = RES_FIND;
      S_INS_HEAD: cmd_o.wr  = WR_INS_HEAD;
      S_INS_A:    cmd_o.wr  = WR_INS_A;
      S_INS_B:    cmd_o.wr  = WR_INS_B;
      S_REM_A:    cmd_o.wr  = WR_REM_A;
      S_REM_B:    cmd_o.wr  = WR_REM_B;
      S_RESP:     cmd_o.out_load = !out_valid_q || out_ready_i;
      default:    cmd_o.latch = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_B |-> $past(state_q) == S_INS_A)
    else $error("link fix-up entered without slot write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_VREAD |-> ($past(state_q) == S_EVAL || $past(state_q) == S_WALK))
    else $error("value read not preceded by lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

### rtl/idll_dp.sv
// Datapath of the indexed list: link, value and free-flag memories plus pointers.
`default_nettype none

module idll_dp #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire idll_pkg::in_t  in_i,
  input  wire idll_pkg::cmd_t cmd_i,
  output idll_pkg::sts_t      sts_o,
  output idll_pkg::out_t      out_o
);
  import idll_pkg::*;

  localparam int unsigned PW = $clog2(SLOTS);

  // memories: next/prev links, values, freed flag (no reset; fill count covers it)
  logic [PW-1:0]         next_mem [SLOTS];
  logic [PW-1:0]         prev_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem  [SLOTS];
  logic                  free_mem [SLOTS];

  logic [PW-1:0]         next_rd_a, next_rd_b, prev_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  free_rd;

  // request
  logic [1:0]            req_act_q;
  logic [5:0]            req_slot_q;
  logic [VALUE_BITS-1:0] req_val_q;
  logic [5:0]            req_rank_q;

  // control pointers
  logic [PW-1:0] head_q, tail_q, recyc_q;
  logic [PW:0]   fill_q;

  // working registers
  logic [PW-1:0]     n_q, nx_q, pv_q, p_q;
  logic [5:0]        cnt_q;
  logic [1:0]        status_q;
  logic [PW-1:0]     rslot_q;
  logic signed [31:0] found_q;

  logic [PW-1:0] addr_a, slot_idx, alloc_n;
  logic          full;

  logic          next_we, prev_we, val_we, free_we, free_wd;
  logic [PW-1:0] next_wa, next_wd, prev_wa, prev_wd, val_wa, free_wa;

  assign slot_idx = PW'(req_slot_q);
  assign full     = (recyc_q == '0) && (32'(fill_q) == SLOTS);
  assign alloc_n  = (recyc_q != '0) ? recyc_q : fill_q[PW-1:0];

  always_comb begin
    case (cmd_i.addr_sel)
      A_REQ:   addr_a = PW'(in_i.slot);
      A_HEAD:  addr_a = head_q;
      A_WALK:  addr_a = next_rd_a;
      default: addr_a = p_q;
    endcase
  end

  // status to controller
  always_comb begin
    sts_o.action    = req_act_q;
    sts_o.empty     = (head_q == '0);
    sts_o.full      = full;
    sts_o.in_use    = (req_slot_q != '0) && (32'(req_slot_q) < 32'(fill_q)) && !free_rd;
    sts_o.rank_zero = (req_rank_q == '0);
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.walk_end  = (next_rd_a == '0);
  end

  // write ports
  always_comb begin
    next_we = 1'b0; next_wa = n_q; next_wd = '0;
    prev_we = 1'b0; prev_wa = n_q; prev_wd = '0;
    val_we  = 1'b0; val_wa  = n_q;
    free_we = 1'b0; free_wa = n_q; free_wd = 1'b0;
    case (cmd_i.wr)
      WR_INS_HEAD: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        free_we = 1'b1;
      end
      WR_INS_A: begin
        val_we  = 1'b1;
        next_we = 1'b1; next_wd = nx_q;
        prev_we = 1'b1; prev_wd = slot_idx;
        free_we = 1'b1;
      end
      WR_INS_B: begin
        next_we = 1'b1; next_wa = slot_idx; next_wd = n_q;
        prev_we = (nx_q != '0); prev_wa = nx_q; prev_wd = n_q;
      end
      WR_REM_A: begin
        next_we = (pv_q != '0); next_wa = pv_q; next_wd = nx_q;
        prev_we = (nx_q != '0); prev_wa = nx_q; prev_wd = pv_q;
        free_we = 1'b1; free_wa = slot_idx; free_wd = 1'b1;
      end
      WR_REM_B: begin
        next_we = 1'b1; next_wa = slot_idx; next_wd = recyc_q;
      end
      default: next_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_a <= next_mem[addr_a];
    next_rd_b <= next_mem[recyc_q];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= req_val_q;
    val_rd <= val_mem[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[addr_a];
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      recyc_q <= '0;
      fill_q  <= (PW+1)'(1);
    end else begin
      if (cmd_i.alloc) begin
        if (recyc_q != '0) recyc_q <= next_rd_b;
        else               fill_q  <= fill_q + 1'b1;
      end
      case (cmd_i.wr)
        WR_INS_HEAD: begin
          head_q <= n_q;
          tail_q <= n_q;
        end
        WR_INS_B: begin
          if (nx_q == '0) tail_q <= n_q;
        end
        WR_REM_A: begin
          if (pv_q == '0) head_q <= nx_q;
          if (nx_q == '0) tail_q <= pv_q;
        end
        WR_REM_B: recyc_q <= slot_idx;
        default:  ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q <= addr_a;
    if (cmd_i.latch) begin
      req_act_q  <= in_i.action;
      req_slot_q <= in_i.slot;
      req_val_q  <= VALUE_BITS'($signed(in_i.item_value));
      req_rank_q <= in_i.rank;
    end
    if (cmd_i.alloc) n_q <= alloc_n;
    if (cmd_i.cap) begin
      nx_q <= next_rd_a;
      pv_q <= prev_rd;
    end
    if (cmd_i.cnt_load)     cnt_q <= req_rank_q - 6'd1;
    else if (cmd_i.cnt_dec) cnt_q <= cnt_q - 6'd1;
    case (cmd_i.res)
      RES_BAD: begin
        status_q <= ST_BAD;
        rslot_q  <= '0;
        found_q  <= '0;
      end
      RES_FULL: begin
        status_q <= ST_FULL;
        rslot_q  <= '0;
        found_q  <= '0;
      end
      RES_INS: begin
        status_q <= ST_OK;
        rslot_q  <= alloc_n;
        found_q  <= '0;
      end
      RES_FIND: begin
        status_q <= ST_OK;
        rslot_q  <= p_q;
        found_q  <= 32'($signed(val_rd));
      end
      RES_OK: begin
        status_q <= ST_OK;
        rslot_q  <= '0;
        found_q  <= '0;
      end
      default: status_q <= status_q;
    endcase
    if (cmd_i.out_load) begin
      out_o.status      <= status_q;
      out_o.result_slot <= 6'(rslot_q);
      out_o.found_value <= found_q;
      out_o.head_slot   <= 6'(head_q);
      out_o.tail_slot   <= 6'(tail_q);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == '0) == (tail_q == '0))
    else $error("head and tail disagree on empty list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 && 32'(fill_q) <= SLOTS)
    else $error("fill count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    recyc_q != '0 |-> recyc_q < fill_q)
    else $error("recycled slot beyond fill count");

endmodule

`default_nettype wire

### rtl/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list with free chain over a slot store.
// Path from input beat to result: a reject goes from lookup straight to the response; insert
// into an empty list adds the head write; insert after a slot adds slot write and link fix-up;
// remove adds unlink and recycle writes; find follows links to the rank or off the tail.
// One request at a time, taken in idle; a waiting result holds the controller in place.
// Reset: asynchronous, active low; list empty, no memory clearing pass (fill count).
`default_nettype none

module indexed_doubly_linked_list #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire idll_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output idll_pkg::out_t      out_o
);
  import idll_pkg::*;

  // controller <-> datapath
  cmd_t cmd;
  sts_t sts;

  // Sequencer: accepts a beat in idle, steps through lookup, link
  // updates or the rank walk, then parks the result in the output register.
  // Link memories have one write port, so insert after a slot and remove
  // spread their link writes over separate states; find follows one link per cycle.
  idll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and pointers. Never-used slots are handed out from a fill
  // counter; removed slots go on a recycled chain through the next links.
  idll_dp #(
    .SLOTS     (SLOTS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_o)
  );

endmodule

`default_nettype wire
